@@ hdl/slt_pkg.sv @@
// shared/exclusive lock table: package with sizes, codes and shared types
// used by slt_cell and shared_exclusive_lock_table; no dependencies
`default_nettype none
package slt_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int KEY_BITS    = 64;
    localparam int OWNER_BITS  = 16;
    localparam int NUM_LVL     = 4;
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int LIM_W       = 6;
    localparam int CTR_W       = (CNT_W > LIM_W) ? CNT_W : LIM_W;

    // request actions
    localparam logic [2:0] MODE_TRY     = 3'd0;
    localparam logic [2:0] MODE_WAIT    = 3'd1;
    localparam logic [2:0] MODE_REL_ONE = 3'd2;
    localparam logic [2:0] MODE_REL_ALL = 3'd3;
    localparam logic [2:0] MODE_CLEAR   = 3'd4;

    // result status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_REFUSED    = 3'd1;
    localparam logic [2:0] ST_NOT_HELD   = 3'd2;
    localparam logic [2:0] ST_ILLEGAL    = 3'd3;
    localparam logic [2:0] ST_INVALID    = 3'd4;
    localparam logic [2:0] ST_WAIT_LEVEL = 3'd5;
    localparam logic [2:0] ST_WAIT_ENTRY = 3'd6;

    // entry kinds
    localparam logic [1:0] KIND_EMPTY = 2'd0;
    localparam logic [1:0] KIND_EXCL  = 2'd1;
    localparam logic [1:0] KIND_SHARE = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_L1 = 2'd0;
    localparam logic [1:0] CFG_L2 = 2'd1;
    localparam logic [1:0] CFG_L3 = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic [2:0]            mode;
        logic [2:0]            level;
        logic [1:0]            want;
        logic [KEY_BITS-1:0]   key;
        logic [OWNER_BITS-1:0] owner;
    } t_req;

    // partial result handed from cell to cell along the chain
    typedef struct packed {
        logic                            hit;
        logic [SLOT_W-1:0]               hit_slot;
        logic                            empty_ok;
        logic [SLOT_W-1:0]               empty_slot;
        logic [CNT_W-1:0]                freed;
        logic                            wake;
        logic [NUM_LVL-1:0][CNT_W-1:0]   lvl_cnt;
    } t_carry;

endpackage
`default_nettype wire

@@ hdl/shared_exclusive_lock_table.sv @@
// shared/exclusive lock table: top level with request control, level counters
// and the chain of entry cells; depends on slt_pkg and slt_cell
//
// usage
// - request channel: i_valid/o_ready with mode, level, kind, key and owner;
//   one transfer is one request
// - result channel: o_valid/i_ready with status, slot, freed count and wake;
//   exactly one result per request, held in an output register
// - configuration channel: i_cfg_valid/o_cfg_ready with index and data, always
//   ready; the three limits are only loaded into the counters on clear-all
// - table-walking requests run a token down the row of 32 entry cells, one
//   cell per cycle, each cell adding its part to the travelling result
// - lock, release and clear requests walk the cell chain before their result;
//   requests refused up front (invalid, illegal action, level counter exhausted)
//   skip the walk and go straight to the result
// - one request at a time: o_ready stays low from the transfer until the
//   result has moved into the output register
// - a new request is taken while the previous result still waits; a finished
//   result then waits until the output register is free
// - reset (synchronous, active low) empties every entry, loads the counters
//   with the table depth and the default limits 16, 16, 8
// - when the receiver stalls, results hold and no further request completes
`default_nettype none
module shared_exclusive_lock_table import slt_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request channel
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [2:0]            i_mode,
    input  logic [2:0]            i_lock_level,
    input  logic [1:0]            i_lock_kind,
    input  logic [KEY_BITS-1:0]   i_lock_key,
    input  logic [OWNER_BITS-1:0] i_owner_id,
    // result channel
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [2:0]            o_status,
    output logic [4:0]            o_slot,
    output logic [5:0]            o_freed_count,
    output logic                  o_wake_waiters,
    // configuration channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [LIM_W-1:0]      i_cfg_data
);

    t_state r_state, n_state;

    // latched request, broadcast to every cell
    t_req   r_req, n_req;
    logic   r_start, n_start;

    // level free counters and limit registers
    logic [NUM_LVL-1:0][CTR_W-1:0] r_free, n_free;
    logic [LIM_W-1:0]              r_lim1, r_lim2, r_lim3;

    // finished result waiting for the output register
    logic [2:0]        r_res_status, n_res_status;
    logic [SLOT_W-1:0] r_res_slot,   n_res_slot;
    logic [CNT_W-1:0]  r_res_freed,  n_res_freed;
    logic              r_res_wake,   n_res_wake;

    // output register
    logic              r_ovalid, n_ovalid;
    logic [2:0]        r_o_status, n_o_status;
    logic [SLOT_W-1:0] r_o_slot,   n_o_slot;
    logic [CNT_W-1:0]  r_o_freed,  n_o_freed;
    logic              r_o_wake,   n_o_wake;

    // grant write into the first empty cell
    logic              grant;
    logic [SLOT_W-1:0] grant_slot;

    // chain wiring
    logic   tok   [TABLE_DEPTH+1];
    t_carry carry [TABLE_DEPTH+1];

    logic in_xfer, avail, bad_req;

    assign tok[0]   = r_start;
    assign carry[0] = '0;

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            slt_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_idx        (SLOT_W'(g)),
                .i_tok        (tok[g]),
                .i_carry      (carry[g]),
                .i_req        (r_req),
                .i_grant      (grant),
                .i_grant_slot (grant_slot),
                .o_tok        (tok[g+1]),
                .o_carry      (carry[g+1])
            );
        end
    endgenerate

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_xfer     = i_valid && o_ready;

    always_comb begin
        n_state      = r_state;
        n_req        = r_req;
        n_start      = 1'b0;
        n_free       = r_free;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        n_res_freed  = r_res_freed;
        n_res_wake   = r_res_wake;
        n_ovalid     = r_ovalid;
        n_o_status   = r_o_status;
        n_o_slot     = r_o_slot;
        n_o_freed    = r_o_freed;
        n_o_wake     = r_o_wake;
        grant        = 1'b0;
        grant_slot   = carry[TABLE_DEPTH].empty_slot;

        // every counter at or below the requested level must be nonzero
        avail = 1'b1;
        for (int j = 0; j < NUM_LVL; j++) begin
            if ((3'(j) <= i_lock_level) && (r_free[j] == '0)) begin
                avail = 1'b0;
            end
        end
        bad_req = i_lock_level[2] || i_lock_kind[1];

        // output register drains on a transfer
        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_req.mode  = i_mode;
                    n_req.level = i_lock_level;
                    n_req.want  = i_lock_kind[0] ? KIND_SHARE : KIND_EXCL;
                    n_req.key   = i_lock_key;
                    n_req.owner = i_owner_id;
                    n_res_slot  = '0;
                    n_res_freed = '0;
                    n_res_wake  = 1'b0;
                    case (i_mode)
                        MODE_TRY, MODE_WAIT: begin
                            if (bad_req) begin
                                n_res_status = ST_INVALID;
                                n_state      = S_FINISH;
                            end else if (!avail) begin
                                n_res_status = (i_mode == MODE_TRY) ? ST_REFUSED
                                                                    : ST_WAIT_LEVEL;
                                n_state      = S_FINISH;
                            end else begin
                                n_start = 1'b1;
                                n_state = S_SCAN;
                            end
                        end
                        MODE_REL_ONE, MODE_REL_ALL, MODE_CLEAR: begin
                            n_start = 1'b1;
                            n_state = S_SCAN;
                        end
                        default: begin
                            n_res_status = ST_ILLEGAL;
                            n_state      = S_FINISH;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (tok[TABLE_DEPTH]) begin
                    n_state      = S_FINISH;
                    n_res_status = ST_OK;
                    n_res_slot   = '0;
                    n_res_freed  = carry[TABLE_DEPTH].freed;
                    n_res_wake   = carry[TABLE_DEPTH].wake;
                    case (r_req.mode)
                        MODE_TRY, MODE_WAIT: begin
                            n_res_freed = '0;
                            n_res_wake  = 1'b0;
                            if (carry[TABLE_DEPTH].hit) begin
                                n_res_status = (r_req.mode == MODE_TRY) ? ST_REFUSED
                                                                        : ST_WAIT_ENTRY;
                                n_res_slot   = carry[TABLE_DEPTH].hit_slot;
                            end else if (carry[TABLE_DEPTH].empty_ok) begin
                                grant      = 1'b1;
                                n_res_slot = carry[TABLE_DEPTH].empty_slot;
                                for (int j = 0; j < NUM_LVL; j++) begin
                                    if (3'(j) <= r_req.level) begin
                                        n_free[j] = r_free[j] - CTR_W'(1);
                                    end
                                end
                            end else begin
                                n_res_status = ST_REFUSED;
                            end
                        end
                        MODE_REL_ONE, MODE_REL_ALL: begin
                            if (r_req.mode == MODE_REL_ONE) begin
                                n_res_status = carry[TABLE_DEPTH].hit ? ST_OK
                                                                      : ST_NOT_HELD;
                                n_res_slot   = carry[TABLE_DEPTH].hit_slot;
                                if (!carry[TABLE_DEPTH].hit) begin
                                    n_res_slot = '0;
                                end
                            end
                            // counters only rise, so a counter leaves zero
                            // exactly when it was zero and gets any free
                            for (int j = 0; j < NUM_LVL; j++) begin
                                n_free[j] = r_free[j]
                                            + CTR_W'(carry[TABLE_DEPTH].lvl_cnt[j]);
                                if (r_free[j] == '0
                                    && carry[TABLE_DEPTH].lvl_cnt[j] != '0) begin
                                    n_res_wake = 1'b1;
                                end
                            end
                        end
                        MODE_CLEAR: begin
                            n_res_wake = 1'b1;
                            n_free[0]  = CTR_W'(TABLE_DEPTH);
                            n_free[1]  = CTR_W'(r_lim1);
                            n_free[2]  = CTR_W'(r_lim2);
                            n_free[3]  = CTR_W'(r_lim3);
                        end
                        default: ;
                    endcase
                end
            end
            S_FINISH: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid   = 1'b1;
                    n_o_status = r_res_status;
                    n_o_slot   = r_res_slot;
                    n_o_freed  = r_res_freed;
                    n_o_wake   = r_res_wake;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_start  <= 1'b0;
            r_ovalid <= 1'b0;
            r_free[0] <= CTR_W'(TABLE_DEPTH);
            r_free[1] <= CTR_W'(16);
            r_free[2] <= CTR_W'(16);
            r_free[3] <= CTR_W'(8);
            r_lim1   <= LIM_W'(16);
            r_lim2   <= LIM_W'(16);
            r_lim3   <= LIM_W'(8);
        end else begin
            r_state  <= n_state;
            r_start  <= n_start;
            r_ovalid <= n_ovalid;
            r_free   <= n_free;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_L1:  r_lim1 <= i_cfg_data;
                    CFG_L2:  r_lim2 <= i_cfg_data;
                    CFG_L3:  r_lim3 <= i_cfg_data;
                    default: ;
                endcase
            end
        end
        r_req        <= n_req;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_res_freed  <= n_res_freed;
        r_res_wake   <= n_res_wake;
        r_o_status   <= n_o_status;
        r_o_slot     <= n_o_slot;
        r_o_freed    <= n_o_freed;
        r_o_wake     <= n_o_wake;
    end

    assign o_valid        = r_ovalid;
    assign o_status       = r_o_status;
    assign o_slot         = 5'(r_o_slot);
    assign o_freed_count  = 6'(r_o_freed);
    assign o_wake_waiters = r_o_wake;

`ifndef NO_ASSERTIONS
    // the token only leaves the last cell while a scan is running
    a_tok_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tok[TABLE_DEPTH] |-> (r_state == S_SCAN))
        else $error("token left chain outside a scan");

    // a request transfer always leads into a scan or straight to a result
    a_xfer_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == S_SCAN || r_state == S_FINISH))
        else $error("request transfer did not start work");

    // level zero counter never exceeds the table size
    a_free0_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free[0] <= CTR_W'(TABLE_DEPTH))
        else $error("level zero free count above table depth");
`endif

endmodule
`default_nettype wire

@@ hdl/slt_cell.sv @@
// shared/exclusive lock table: one table entry with its step of the scan
// depends on slt_pkg
`default_nettype none
module slt_cell import slt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [SLOT_W-1:0] i_idx,
    input  logic              i_tok,
    input  t_carry            i_carry,
    input  t_req              i_req,
    input  logic              i_grant,
    input  logic [SLOT_W-1:0] i_grant_slot,
    output logic              o_tok,
    output t_carry            o_carry
);

    logic [1:0]            r_kind,    n_kind;
    logic [1:0]            r_level,   n_level;
    logic [OWNER_BITS-1:0] r_owner,   n_owner;
    logic [KEY_BITS-1:0]   r_key,     n_key;
    logic                  r_waiting, n_waiting;
    logic                  r_tok;
    t_carry                r_carry,   n_carry;

    logic live, match, own, do_free;

    always_comb begin
        n_kind    = r_kind;
        n_level   = r_level;
        n_owner   = r_owner;
        n_key     = r_key;
        n_waiting = r_waiting;
        n_carry   = i_carry;
        do_free   = 1'b0;
        live  = (r_kind != KIND_EMPTY);
        own   = (r_owner == i_req.owner);
        // same key and level; a request level above three never matches
        match = live && (r_key == i_req.key) && !i_req.level[2]
                && (r_level == i_req.level[1:0]);
        if (i_tok) begin
            case (i_req.mode)
                MODE_TRY, MODE_WAIT: begin
                    if (match && !i_carry.hit
                        && (r_kind == KIND_EXCL || i_req.want == KIND_EXCL)) begin
                        n_carry.hit      = 1'b1;
                        n_carry.hit_slot = i_idx;
                        if (i_req.mode == MODE_WAIT) begin
                            n_waiting = 1'b1;
                        end
                    end
                    if (!live && !i_carry.empty_ok) begin
                        n_carry.empty_ok   = 1'b1;
                        n_carry.empty_slot = i_idx;
                    end
                end
                MODE_REL_ONE: begin
                    if (match && own && !i_carry.hit) begin
                        n_carry.hit      = 1'b1;
                        n_carry.hit_slot = i_idx;
                        do_free          = 1'b1;
                    end
                end
                MODE_REL_ALL: begin
                    do_free = live && own;
                end
                MODE_CLEAR: begin
                    if (live) begin
                        n_carry.freed = i_carry.freed + CNT_W'(1);
                    end
                    n_kind    = KIND_EMPTY;
                    n_level   = 2'd0;
                    n_owner   = '0;
                    n_key     = '0;
                    n_waiting = 1'b0;
                end
                default: ;
            endcase
        end
        if (do_free) begin
            n_kind        = KIND_EMPTY;
            n_owner       = '0;
            n_waiting     = 1'b0;
            n_carry.freed = i_carry.freed + CNT_W'(1);
            if (r_waiting) begin
                n_carry.wake = 1'b1;
            end
            for (int j = 0; j < NUM_LVL; j++) begin
                if (2'(j) <= r_level) begin
                    n_carry.lvl_cnt[j] = i_carry.lvl_cnt[j] + CNT_W'(1);
                end
            end
        end
        if (i_grant && (i_grant_slot == i_idx)) begin
            n_kind  = i_req.want;
            n_level = i_req.level[1:0];
            n_owner = i_req.owner;
            n_key   = i_req.key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind    <= KIND_EMPTY;
            r_level   <= 2'd0;
            r_owner   <= '0;
            r_key     <= '0;
            r_waiting <= 1'b0;
            r_tok     <= 1'b0;
        end else begin
            r_kind    <= n_kind;
            r_level   <= n_level;
            r_owner   <= n_owner;
            r_key     <= n_key;
            r_waiting <= n_waiting;
            r_tok     <= i_tok;
        end
        r_carry <= n_carry;
    end

    assign o_tok   = r_tok;
    assign o_carry = r_carry;

endmodule
`default_nettype wire

@@ dv/shared_exclusive_lock_table_test.sv @@
// testbench for shared_exclusive_lock_table: directed and random requests, checked
// against a cycle-free model of the lock table; depends on slt_pkg and the block rtl
`default_nettype none
module shared_exclusive_lock_table_test;
    import slt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // codes above clear-all are illegal actions
    localparam logic [2:0] MODE_FIRST_ILLEGAL = 3'd5;
    localparam logic [1:0] LOCK_EXCL  = 2'd0;
    localparam logic [1:0] LOCK_SHARE = 2'd1;
    localparam int         STALL_LIMIT = 4000;
    localparam int         RANDOM_ITEMS = 1100;

    typedef struct packed {
        logic [2:0] status;
        logic [4:0] slot;
        logic [5:0] freed;
        logic       wake;
    } t_lock_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic [2:0]            i_mode = '0;
    logic [2:0]            i_lock_level = '0;
    logic [1:0]            i_lock_kind = '0;
    logic [KEY_BITS-1:0]   i_lock_key = '0;
    logic [OWNER_BITS-1:0] i_owner_id = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [2:0]            o_status;
    logic [4:0]            o_slot;
    logic [5:0]            o_freed_count;
    logic                  o_wake_waiters;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [1:0]            i_cfg_index = '0;
    logic [LIM_W-1:0]      i_cfg_data = '0;

    shared_exclusive_lock_table u_top (.*);

    always #4 i_clk = ~i_clk;

    // model of the table, updated at each request transfer
    logic [1:0]            tbl_kind  [TABLE_DEPTH];
    logic [1:0]            tbl_level [TABLE_DEPTH];
    logic [OWNER_BITS-1:0] tbl_owner [TABLE_DEPTH];
    logic [KEY_BITS-1:0]   tbl_key   [TABLE_DEPTH];
    logic                  tbl_wait  [TABLE_DEPTH];
    int                    free_cnt  [NUM_LVL];
    logic [LIM_W-1:0]      limit_reg [3];

    t_lock_result pending_results[$];
    int           mismatches = 0;
    bit           idle_on = 1'b1;
    int           hold_off = 0;
    int           quiet_cycles = 0;
    logic [KEY_BITS-1:0]   key_pool[4];
    logic [OWNER_BITS-1:0] owner_pool[4];

    function automatic void empty_table();
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            tbl_kind[k]  = KIND_EMPTY;
            tbl_level[k] = '0;
            tbl_owner[k] = '0;
            tbl_key[k]   = '0;
            tbl_wait[k]  = 1'b0;
        end
        free_cnt[0] = TABLE_DEPTH;
        for (int j = 1; j < NUM_LVL; j++) free_cnt[j] = limit_reg[j-1];
    endfunction

    // frees entry k if held by owner, restoring the level counters
    function automatic int drop_entry(int k, logic [OWNER_BITS-1:0] owner, ref logic wake);
        if (tbl_kind[k] == KIND_EMPTY || tbl_owner[k] != owner) return 0;
        tbl_kind[k]  = KIND_EMPTY;
        tbl_owner[k] = '0;
        if (tbl_wait[k]) begin
            tbl_wait[k] = 1'b0;
            wake = 1'b1;
        end
        for (int j = 0; j <= tbl_level[k]; j++) begin
            if (free_cnt[j] == 0) wake = 1'b1;
            if (free_cnt[j] != 65535) free_cnt[j]++;
        end
        return 1;
    endfunction

    function automatic t_lock_result predict_lock_result(logic [2:0] mode, logic [2:0] lvl,
            logic [1:0] kind, logic [KEY_BITS-1:0] key, logic [OWNER_BITS-1:0] owner);
        t_lock_result r;
        logic [1:0]   want;
        bit           avail;
        bit           clash;
        int           freed;
        logic         wake;
        r = '0;
        freed = 0;
        wake = 1'b0;
        clash = 1'b0;
        if (mode == MODE_TRY || mode == MODE_WAIT) begin
            if (lvl > 3 || kind > LOCK_SHARE) begin
                r.status = ST_INVALID;
            end else begin
                want = (kind == LOCK_EXCL) ? KIND_EXCL : KIND_SHARE;
                avail = 1'b1;
                for (int j = 0; j <= lvl; j++) if (free_cnt[j] == 0) avail = 1'b0;
                if (!avail) begin
                    r.status = (mode == MODE_TRY) ? ST_REFUSED : ST_WAIT_LEVEL;
                end else begin
                    for (int k = 0; k < TABLE_DEPTH; k++) begin
                        if (!clash && tbl_kind[k] != KIND_EMPTY && tbl_key[k] == key &&
                            tbl_level[k] == lvl[1:0] &&
                            (tbl_kind[k] == KIND_EXCL || want == KIND_EXCL)) begin
                            clash = 1'b1;
                            r.slot = k[4:0];
                        end
                    end
                    if (clash) begin
                        if (mode == MODE_TRY) begin
                            r.status = ST_REFUSED;
                        end else begin
                            r.status = ST_WAIT_ENTRY;
                            tbl_wait[r.slot] = 1'b1;
                        end
                    end else begin
                        r.status = ST_REFUSED;
                        for (int k = 0; k < TABLE_DEPTH; k++) begin
                            if (r.status != ST_OK && tbl_kind[k] == KIND_EMPTY) begin
                                tbl_kind[k]  = want;
                                tbl_level[k] = lvl[1:0];
                                tbl_owner[k] = owner;
                                tbl_key[k]   = key;
                                for (int j = 0; j <= lvl; j++) free_cnt[j]--;
                                r.status = ST_OK;
                                r.slot   = k[4:0];
                            end
                        end
                    end
                end
            end
        end else if (mode == MODE_REL_ONE) begin
            r.status = ST_NOT_HELD;
            for (int k = 0; k < TABLE_DEPTH; k++) begin
                if (r.status != ST_OK && tbl_kind[k] != KIND_EMPTY && tbl_key[k] == key &&
                    {1'b0, tbl_level[k]} == lvl && tbl_owner[k] == owner) begin
                    freed = drop_entry(k, owner, wake);
                    r.status = ST_OK;
                    r.slot   = k[4:0];
                end
            end
        end else if (mode == MODE_REL_ALL) begin
            for (int k = 0; k < TABLE_DEPTH; k++) freed += drop_entry(k, owner, wake);
        end else if (mode == MODE_CLEAR) begin
            for (int k = 0; k < TABLE_DEPTH; k++) if (tbl_kind[k] != KIND_EMPTY) freed++;
            empty_table();
            wake = 1'b1;
        end else begin
            r.status = ST_ILLEGAL;
        end
        r.freed = freed[5:0];
        r.wake  = wake;
        return r;
    endfunction

    // offers one request and waits for its transfer; the model runs on acceptance
    task automatic send_request(logic [2:0] mode, logic [2:0] lvl, logic [1:0] kind,
            logic [KEY_BITS-1:0] key, logic [OWNER_BITS-1:0] owner);
        while (idle_on && $urandom_range(99) < 15) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_mode       <= mode;
        i_lock_level <= lvl;
        i_lock_kind  <= kind;
        i_lock_key   <= key;
        i_owner_id   <= owner;
        do @(posedge i_clk); while (!o_ready);
        pending_results.push_back(predict_lock_result(mode, lvl, kind, key, owner));
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // register writes only happen with the table idle
    task automatic write_limit(logic [1:0] idx, logic [LIM_W-1:0] value);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        limit_reg[idx] = value;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_directed();
        send_request(MODE_TRY, 3'd0, LOCK_EXCL, '1, '1);
        send_request(MODE_TRY, 3'd0, LOCK_SHARE, '1, 16'h0001);
        send_request(MODE_WAIT, 3'd0, LOCK_SHARE, '1, 16'h0002);
        send_request(MODE_TRY, 3'd3, LOCK_SHARE, 64'h0, 16'h0);
        send_request(MODE_TRY, 3'd3, LOCK_SHARE, 64'h0, 16'h0003);
        send_request(MODE_WAIT, 3'd3, LOCK_EXCL, 64'h0, 16'h0004);
        send_request(MODE_TRY, 3'd4, LOCK_EXCL, 64'h5, 16'h0);
        send_request(MODE_WAIT, 3'd7, LOCK_SHARE, 64'h5, 16'h0);
        send_request(MODE_TRY, 3'd1, 2'd2, 64'h5, 16'h0);
        send_request(MODE_WAIT, 3'd1, 2'd3, 64'h5, 16'h0);
        send_request(MODE_REL_ONE, 3'd0, LOCK_EXCL, '1, 16'h0002);
        send_request(MODE_REL_ONE, 3'd0, LOCK_EXCL, '1, '1);
        send_request(MODE_REL_ONE, 3'd3, LOCK_EXCL, 64'h0, 16'h0);
        send_request(MODE_REL_ALL, 3'd0, LOCK_EXCL, 64'h0, 16'h0003);
        send_request(MODE_REL_ALL, 3'd0, LOCK_EXCL, 64'h0, 16'h7777);
        for (int m = 0; m < 3; m++)
            send_request(MODE_FIRST_ILLEGAL + m[2:0], 3'd2, LOCK_SHARE, 64'h9, 16'h9);
        send_request(MODE_CLEAR, 3'd0, LOCK_EXCL, 64'h0, 16'h0);
    endtask

    // fill all slots at level zero, then one more is refused or waits on the counter
    task automatic test_table_full();
        for (int k = 0; k < TABLE_DEPTH; k++)
            send_request(MODE_TRY, 3'd0, LOCK_SHARE, 64'h1000 + k, 16'h00aa);
        send_request(MODE_TRY, 3'd0, LOCK_SHARE, 64'h2000, 16'h00bb);
        send_request(MODE_WAIT, 3'd0, LOCK_EXCL, 64'h2000, 16'h00bb);
        send_request(MODE_REL_ONE, 3'd0, LOCK_SHARE, 64'h1005, 16'h00aa);
        send_request(MODE_REL_ALL, 3'd0, LOCK_EXCL, 64'h0, 16'h00aa);
    endtask

    // limits at their extremes, applied through clear-all
    task automatic test_limits(logic [LIM_W-1:0] l1, logic [LIM_W-1:0] l2,
            logic [LIM_W-1:0] l3);
        write_limit(CFG_L1, l1);
        write_limit(CFG_L2, l2);
        write_limit(CFG_L3, l3);
        send_request(MODE_CLEAR, 3'd0, LOCK_EXCL, 64'h0, 16'h0);
        for (int k = 0; k < 6; k++)
            send_request(MODE_WAIT, k[1:0] + 3'd1, LOCK_EXCL, 64'h3000 + k, 16'h0011);
        send_request(MODE_REL_ALL, 3'd0, LOCK_EXCL, 64'h0, 16'h0011);
    endtask

    task automatic test_random(int count);
        logic [2:0]            mode;
        logic [2:0]            lvl;
        logic [1:0]            kind;
        logic [KEY_BITS-1:0]   key;
        logic [OWNER_BITS-1:0] owner;
        int                    pick;
        for (int n = 0; n < count; n++) begin
            idle_on = !(n >= 300 && n < 450);
            pick = $urandom_range(99);
            mode  = (pick < 30) ? MODE_TRY : (pick < 55) ? MODE_WAIT :
                    (pick < 82) ? MODE_REL_ONE : (pick < 92) ? MODE_REL_ALL :
                    (pick < 95) ? MODE_CLEAR : 3'($urandom_range(7));
            lvl   = ($urandom_range(19) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(3));
            kind  = ($urandom_range(19) == 0) ? 2'($urandom_range(3)) : 2'($urandom_range(1));
            key   = key_pool[$urandom_range(3)];
            owner = owner_pool[$urandom_range(3)];
            // a little noise with arbitrary keys and owners
            if ($urandom_range(9) == 0) key = {$urandom, $urandom};
            if ($urandom_range(9) == 0) owner = 16'($urandom);
            send_request(mode, lvl, kind, key, owner);
        end
        idle_on = 1'b1;
    endtask

    // receiver holds off long enough for requests to back up behind the table
    task automatic test_backpressure();
        hold_off = 300;
        for (int n = 0; n < 12; n++)
            send_request(MODE_TRY, 3'($urandom_range(3)), LOCK_SHARE, key_pool[n % 4],
                         owner_pool[0]);
        send_request(MODE_REL_ALL, 3'd0, LOCK_EXCL, 64'h0, owner_pool[0]);
    endtask

    // result side: random stalls outside the long hold-off
    int rx_phase = 0;
    always @(posedge i_clk) begin
        rx_phase <= (rx_phase + 1) % 2000;
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_ready  <= 1'b0;
        end else begin
            i_ready <= (rx_phase < 300) ? 1'b1 : ($urandom_range(99) >= 15);
        end
    end

    // result checking against the oldest expectation
    always @(posedge i_clk) begin
        t_lock_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: status %0d slot %0d",
                             o_status, o_slot);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status || o_slot !== want.slot ||
                    o_freed_count !== want.freed || o_wake_waiters !== want.wake) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result mismatch: exp st %0d slot %0d freed %0d wake %0d,",
                                  " got st %0d slot %0d freed %0d wake %0d"},
                                 want.status, want.slot, want.freed, want.wake,
                                 o_status, o_slot, o_freed_count, o_wake_waiters);
                end
            end
        end
    end

    // watchdog on cycles with no transfer on any channel while results are pending
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready) ||
            pending_results.size() == 0)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        limit_reg[0] = 6'd16;
        limit_reg[1] = 6'd16;
        limit_reg[2] = 6'd8;
        empty_table();
        for (int k = 0; k < 4; k++) begin
            key_pool[k]   = {$urandom, $urandom};
            owner_pool[k] = 16'($urandom);
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_table_full();
        test_limits(6'd0, 6'd32, 6'd0);
        test_limits(6'd32, 6'd0, 6'd32);
        test_limits(6'd1, 6'd1, 6'd1);
        test_limits(6'($urandom_range(32)), 6'($urandom_range(32)), 6'($urandom_range(32)));
        send_request(MODE_CLEAR, 3'd0, LOCK_EXCL, 64'h0, 16'h0);
        test_random(RANDOM_ITEMS);
        test_backpressure();
        test_limits(6'd2, 6'd1, 6'd0);
        test_random(RANDOM_ITEMS / 10);
        drain_results();
        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
`default_nettype wire

@@ filelist.f @@
hdl/slt_pkg.sv
hdl/slt_cell.sv
hdl/shared_exclusive_lock_table.sv
dv/shared_exclusive_lock_table_test.sv
